// ----- rtl/tskf_pkg.sv -----
package tskf_pkg;

   // Fixed field widths (Q16.16 words on every channel)
   localparam int DATA_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register map: index taken from paddr[2]
   localparam logic [0:0] REG_MEAS_NOISE = 1'b0;
   localparam logic [0:0] REG_PROC_NOISE = 1'b1;

   // Register reset values: R = 2000.0, Q = 1.0
   localparam logic [CSR_DATA_W-1:0] MEAS_NOISE_RESET = 32'd131072000;
   localparam logic [CSR_DATA_W-1:0] PROC_NOISE_RESET = 32'd65536;

   // Per-cycle commands from the sequencer to every lane
   typedef struct packed {
      logic load;       // word accepted: latch innovation, S, divider seed
      logic div_step;   // one restoring division step
      logic mul;        // gain products
      logic rnd;        // rounding of both products
      logic commit;     // write back estimate and variance
   } lane_ctrl_type;

endpackage

// ----- rtl/three_axis_scalar_kalman_filter.sv -----
// Three-axis scalar Kalman filter, random-walk model, Q16.16 fixed point.
// req channel: one word carries a velocity sample per axis; the block keeps
// an estimate and an error variance per axis and returns one rsp word with
// the new estimate of every axis for each req word.
// csr port: APB-style; measurement noise R at 0x0, process noise Q at 0x4.
// Write them only while no word is in flight.
// The restoring divider in each lane produces one gain bit a cycle, followed
// by product, rounding and write-back cycles; rsp_tvalid rises once the
// result is written to the output register. One word is in flight at a
// time, so a new req word is taken only after the last one is written back.
// The result sits in an output register: while it waits, the next req word
// is accepted and processed; write-back holds until the register frees up.
// Reset clears all estimates and variances to zero and restores R = 2000.0
// and Q = 1.0; the block takes a req word in the first cycle after reset.
module three_axis_scalar_kalman_filter #(
   parameter int AXES      = 3,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: sample_x, sample_y, sample_z (32 bits each, lowest first)
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [AXES*tskf_pkg::DATA_W-1:0]      req_tdata,
   // rsp_tdata: estimate_x, estimate_y, estimate_z (32 bits each, lowest first)
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [AXES*tskf_pkg::DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tskf_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [tskf_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [tskf_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type                               state_ff, state_in;
   logic [CNT_W-1:0]                        cnt_ff, cnt_in;
   logic                                    rnd_ff, rnd_in;
   logic                                    req_accept;
   logic                                    slot_free;
   logic                                    commit;
   tskf_pkg::lane_ctrl_type                 ctrl;
   logic [tskf_pkg::CSR_DATA_W-1:0]         meas_noise;
   logic [tskf_pkg::CSR_DATA_W-1:0]         proc_noise;
   logic [AXES-1:0][tskf_pkg::DATA_W-1:0]   lane_est;

   tskf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .meas_noise  (meas_noise),
      .proc_noise  (proc_noise)
   );

   // Sequencer: IDLE -> DIV (FRAC_BITS+1 steps) -> MUL -> FIN (round, then commit)
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;
   assign commit     = (state_ff == ST_FIN) && rnd_ff && slot_free;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_FIN;
            rnd_in   = 1'b0;
         end
         ST_FIN: begin
            rnd_in = 1'b1;
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rnd_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rnd_ff   <= rnd_in;
      end
   end

   // Lane commands
   always_comb begin
      ctrl.load     = req_accept;
      ctrl.div_step = (state_ff == ST_DIV);
      ctrl.mul      = (state_ff == ST_MUL);
      ctrl.rnd      = (state_ff == ST_FIN) && !rnd_ff;
      ctrl.commit   = commit;
   end

   // One filter lane per axis
   for (genvar g = 0; g < AXES; g++) begin : g_lane
      tskf_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .sample     (req_tdata[g*tskf_pkg::DATA_W +: tskf_pkg::DATA_W]),
         .meas_noise (meas_noise),
         .proc_noise (proc_noise),
         .est_next   (lane_est[g])
      );
   end

   // Gather lane estimates into the result word
   tskf_merge #(
      .AXES (AXES)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .commit     (commit),
      .lane_est   (lane_est),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/tskf_csr.sv -----
module tskf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tskf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tskf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tskf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [tskf_pkg::CSR_DATA_W-1:0]     meas_noise,
   output logic [tskf_pkg::CSR_DATA_W-1:0]     proc_noise
);

   logic [tskf_pkg::CSR_DATA_W-1:0] meas_noise_ff;
   logic [tskf_pkg::CSR_DATA_W-1:0] proc_noise_ff;
   logic [0:0]                      reg_index;
   logic                            wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Register writes on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         meas_noise_ff <= tskf_pkg::MEAS_NOISE_RESET;
         proc_noise_ff <= tskf_pkg::PROC_NOISE_RESET;
      end else if (wr_en) begin
         unique case (reg_index)
            tskf_pkg::REG_MEAS_NOISE: meas_noise_ff <= csr_pwdata;
            tskf_pkg::REG_PROC_NOISE: proc_noise_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_index)
         tskf_pkg::REG_MEAS_NOISE: csr_prdata = meas_noise_ff;
         tskf_pkg::REG_PROC_NOISE: csr_prdata = proc_noise_ff;
         default:                  csr_prdata = '0;
      endcase
   end

   assign meas_noise = meas_noise_ff;
   assign proc_noise = proc_noise_ff;

endmodule

// ----- rtl/tskf_lane.sv -----
module tskf_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tskf_pkg::lane_ctrl_type             ctrl,
   input  logic [tskf_pkg::DATA_W-1:0]         sample,
   input  logic [tskf_pkg::DATA_W-1:0]         meas_noise,
   input  logic [tskf_pkg::DATA_W-1:0]         proc_noise,
   output logic [tskf_pkg::DATA_W-1:0]         est_next
);

   localparam int DW   = tskf_pkg::DATA_W;
   localparam int S_W  = DW + 1;               // P + R
   localparam int REM_W = DW + 2;              // partial remainder, below 2*S
   localparam int K_W  = FRAC_BITS + 1;        // gain, at most 1.0
   localparam int IN_W = DW + 1;               // innovation
   localparam int PE_W = K_W + 1 + IN_W;       // gain * innovation, signed
   localparam int PP_W = K_W + DW;             // gain * variance
   localparam int C_W  = PE_W - FRAC_BITS;     // rounded correction
   localparam int E_W  = C_W + 1;              // estimate sum
   localparam logic [PE_W-1:0] HALF_E = PE_W'(1) << (FRAC_BITS - 1);
   localparam logic [PP_W-1:0] HALF_P = PP_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [E_W-1:0] EST_MAX = E_W'(2147483647);
   localparam logic signed [E_W-1:0] EST_MIN = -E_W'(64'sd2147483648);

   // Filter state
   logic [DW-1:0]               est_ff, est_in;
   logic [DW-1:0]               var_ff, var_in;

   // Working registers
   logic [S_W-1:0]              s_ff, s_in;
   logic                        s_zero_ff, s_zero_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [K_W-1:0]              quo_ff, quo_in;
   logic signed [IN_W-1:0]      innov_ff, innov_in;
   logic signed [PE_W-1:0]      prod_e_ff, prod_e_in;
   logic [PP_W-1:0]             prod_p_ff, prod_p_in;
   logic signed [C_W-1:0]       corr_ff, corr_in;
   logic [DW-1:0]               kp_ff, kp_in;

   logic [REM_W-1:0]            s_ext;
   logic [REM_W-1:0]            diff;
   logic                        ge;
   logic [K_W-1:0]              k_eff;
   logic signed [PE_W-1:0]      rnd_sum;
   logic [PP_W-1:0]             kp_sum;
   logic [S_W-1:0]              kp_raw;
   logic signed [E_W-1:0]       est_sum;
   logic [S_W-1:0]              var_sum;

   // Restoring divider step: one gain bit per cycle, MSB first
   assign s_ext = {1'b0, s_ff};
   assign diff  = rem_ff - s_ext;
   assign ge    = (rem_ff >= s_ext);

   // Zero innovation variance forces a zero gain
   assign k_eff = s_zero_ff ? '0 : quo_ff;

   // Round gain*innovation: nearest, ties away from zero
   assign rnd_sum = prod_e_ff + (prod_e_ff[PE_W-1] ? (HALF_E - PE_W'(1)) : HALF_E);
   // Round gain*variance: nearest, ties up
   assign kp_sum  = prod_p_ff + HALF_P;
   assign kp_raw  = kp_sum[PP_W-1:FRAC_BITS];

   // Write-back values
   assign est_sum = E_W'($signed(est_ff)) + E_W'(corr_ff);
   assign var_sum = {1'b0, var_ff} - {1'b0, kp_ff} + {1'b0, proc_noise};

   always_comb begin
      if (est_sum > EST_MAX) begin
         est_next = DW'(EST_MAX);
      end else if (est_sum < EST_MIN) begin
         est_next = DW'(EST_MIN);
      end else begin
         est_next = est_sum[DW-1:0];
      end
   end

   always_comb begin
      est_in = est_ff;
      var_in = var_ff;
      if (ctrl.commit) begin
         est_in = est_next;
         var_in = var_sum[DW] ? '1 : var_sum[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= '0;
         var_ff <= '0;
      end else begin
         est_ff <= est_in;
         var_ff <= var_in;
      end
   end

   // Datapath next values
   always_comb begin
      s_in      = s_ff;
      s_zero_in = s_zero_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      innov_in  = innov_ff;
      prod_e_in = prod_e_ff;
      prod_p_in = prod_p_ff;
      corr_in   = corr_ff;
      kp_in     = kp_ff;
      if (ctrl.load) begin
         s_in      = {1'b0, var_ff} + {1'b0, meas_noise};
         s_zero_in = (var_ff == '0) && (meas_noise == '0);
         rem_in    = {2'b00, var_ff};
         quo_in    = '0;
         innov_in  = $signed({sample[DW-1], sample}) - $signed({est_ff[DW-1], est_ff});
      end
      if (ctrl.div_step) begin
         rem_in = ge ? (diff << 1) : (rem_ff << 1);
         quo_in = {quo_ff[K_W-2:0], ge};
      end
      if (ctrl.mul) begin
         prod_e_in = PE_W'($signed({1'b0, k_eff})) * innov_ff;
         prod_p_in = PP_W'(k_eff) * var_ff;
      end
      if (ctrl.rnd) begin
         corr_in = rnd_sum[PE_W-1:FRAC_BITS];
         kp_in   = (kp_raw > {1'b0, var_ff}) ? var_ff : kp_raw[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      s_zero_ff <= s_zero_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      innov_ff  <= innov_in;
      prod_e_ff <= prod_e_in;
      prod_p_ff <= prod_p_in;
      corr_ff   <= corr_in;
      kp_ff     <= kp_in;
   end

endmodule

// ----- rtl/tskf_merge.sv -----
module tskf_merge #(
   parameter int AXES = 3
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        commit,
   input  logic [AXES-1:0][tskf_pkg::DATA_W-1:0]       lane_est,
   output logic                                        slot_free,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [AXES*tskf_pkg::DATA_W-1:0]            rsp_tdata
);

   logic                                    valid_ff, valid_in;
   logic [AXES-1:0][tskf_pkg::DATA_W-1:0]   data_ff, data_in;

   // Slot frees up in the cycle its word is taken
   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (commit) begin
         valid_in = 1'b1;
         data_in  = lane_est;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

   localparam int AXES = 3;
   localparam int FRAC_BITS = 16;
   localparam int DW = tskf_pkg::DATA_W;
   localparam int SETTLE_LIMIT = 5000;
   localparam int TAIL_CYCLES = FRAC_BITS + 10;
   localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam longint EST_MAX = 64'sd2147483647;
   localparam longint EST_MIN = -64'sd2147483648;
   localparam longint unsigned VAR_MAX = 64'hFFFF_FFFF;
   localparam logic [DW-1:0] S_MIN = 32'h8000_0000;
   localparam logic [DW-1:0] S_MAX = 32'h7FFF_FFFF;
   localparam logic [DW-1:0] EXTREMES [5] =
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
   localparam string AXIS_NAME [AXES] = '{"x", "y", "z"};

   typedef logic [AXES*DW-1:0] word_type;

   // DUT inputs, all driven to known values from time zero
   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   word_type req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   word_type rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [tskf_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [tskf_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [tskf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // filter state as the block should hold it
   logic [DW-1:0] track_est [AXES];
   logic [DW-1:0] track_var [AXES];
   logic [tskf_pkg::CSR_DATA_W-1:0] noise_r = tskf_pkg::MEAS_NOISE_RESET;
   logic [tskf_pkg::CSR_DATA_W-1:0] noise_q = tskf_pkg::PROC_NOISE_RESET;
   word_type pending_estimates [$];

   // stimulus knobs and counters
   int send_idle_pct = 0;
   int sink_stall_pct = 0;
   int truth [AXES];
   int mismatch_count = 0;
   int samples_sent = 0;
   int words_checked = 0;
   int reg_writes = 0;

   three_axis_scalar_kalman_filter #(
      .AXES(AXES),
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      for (int a = 0; a < AXES; a++) begin
         track_est[a] = '0;
         track_var[a] = '0;
         truth[a] = 0;
      end
   end

   task automatic note_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // one axis of the filter: gain, estimate update, variance update
   function automatic logic [DW-1:0] advance_axis(input int a, input logic [DW-1:0] raw);
      longint unsigned p, s, gain, kp, np;
      longint meas, est, innov, prod, corr, nxt;
      p = 64'(track_var[a]);
      s = p + 64'(noise_r);
      gain = (s != 0) ? (p << FRAC_BITS) / s : 64'd0;
      meas = longint'($signed(raw));
      est = longint'($signed(track_est[a]));
      innov = meas - est;
      prod = longint'(gain) * innov;
      // round to nearest, ties away from zero
      if (prod < 0) begin
         corr = -((-prod + ROUND_HALF) >>> FRAC_BITS);
      end else begin
         corr = (prod + ROUND_HALF) >>> FRAC_BITS;
      end
      nxt = est + corr;
      if (nxt > EST_MAX) nxt = EST_MAX;
      if (nxt < EST_MIN) nxt = EST_MIN;
      track_est[a] = nxt[DW-1:0];
      // variance: ties round upward, then saturate
      kp = (gain * p + ROUND_HALF) >> FRAC_BITS;
      if (kp > p) kp = p;
      np = p - kp + 64'(noise_q);
      if (np > VAR_MAX) np = VAR_MAX;
      track_var[a] = np[DW-1:0];
      return track_est[a];
   endfunction

   function automatic word_type predict_estimates(input word_type samples);
      word_type est_word;
      for (int a = 0; a < AXES; a++) begin
         est_word[a*DW +: DW] = advance_axis(a, samples[a*DW +: DW]);
      end
      return est_word;
   endfunction

   // result checking first, then prediction of the newly accepted word
   always @(posedge clock) begin
      word_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_estimates.size() == 0) begin
               note_mismatch($sformatf("estimate word %h with nothing pending", rsp_tdata));
            end else begin
               want = pending_estimates.pop_front();
               for (int a = 0; a < AXES; a++) begin
                  if (rsp_tdata[a*DW +: DW] !== want[a*DW +: DW]) begin
                     note_mismatch($sformatf("word %0d estimate_%s: expected %h, got %h",
                        words_checked, AXIS_NAME[a], want[a*DW +: DW], rsp_tdata[a*DW +: DW]));
                  end
               end
            end
            words_checked++;
         end
         if (req_tvalid && req_tready) begin
            pending_estimates.push_back(predict_estimates(req_tdata));
            samples_sent++;
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
   end

   // entered and left at a falling edge
   task automatic send_sample(input logic [DW-1:0] sx, input logic [DW-1:0] sy,
                              input logic [DW-1:0] sz);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {sz, sy, sx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // wait for every pending estimate, then let the pipeline run dry
   task automatic settle();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0 && waited < SETTLE_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic read_register(input logic [0:0] idx);
      logic [tskf_pkg::CSR_DATA_W-1:0] got, want;
      want = (idx == tskf_pkg::REG_MEAS_NOISE) ? noise_r : noise_q;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         note_mismatch($sformatf("register %0d read: expected %h, got %h", idx, want, got));
      end
   endtask

   task automatic set_register(input logic [0:0] idx,
                               input logic [tskf_pkg::CSR_DATA_W-1:0] value);
      settle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         tskf_pkg::REG_MEAS_NOISE: noise_r = value;
         tskf_pkg::REG_PROC_NOISE: noise_q = value;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      read_register(idx);
   endtask

   // mostly a noisy slowly drifting velocity, some full-range noise and extremes
   function automatic logic [DW-1:0] pick_sample(input int a);
      int unsigned roll;
      int step;
      int jitter;
      roll = $urandom_range(99, 0);
      if (roll < 10) return EXTREMES[$urandom_range(4, 0)];
      if (roll < 30) return $urandom();
      step = int'($urandom_range(131072, 0)) - 65536;
      jitter = int'($urandom_range(524288, 0)) - 262144;
      truth[a] += step;
      if (truth[a] > 6553600) truth[a] = 6553600;
      if (truth[a] < -6553600) truth[a] = -6553600;
      return truth[a] + jitter;
   endfunction

   task automatic test_reset_state();
      read_register(tskf_pkg::REG_MEAS_NOISE);
      read_register(tskf_pkg::REG_PROC_NOISE);
      send_sample('0, '0, '0);
      send_sample(S_MAX, S_MIN, 32'h1);
      send_sample(S_MIN, S_MAX, 32'hFFFF_FFFF);
      send_sample(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
      send_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_8000);
      send_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_8000);
   endtask

   // R = 0: gain of exactly one while P > 0, zero gain once S is zero
   task automatic test_zero_noise();
      set_register(tskf_pkg::REG_MEAS_NOISE, '0);
      set_register(tskf_pkg::REG_PROC_NOISE, '0);
      send_sample(S_MIN, S_MAX, '0);
      send_sample(S_MAX, S_MIN, 32'hFFFF_FFFF);
      send_sample(S_MAX, S_MIN, 32'h1);
      set_register(tskf_pkg::REG_PROC_NOISE, 32'h1);
      send_sample(S_MIN, S_MAX, 32'h1234_5678);
      send_sample(S_MAX, S_MIN, 32'h1);
   endtask

   // huge Q and R drive the variance into saturation
   task automatic test_variance_saturation();
      set_register(tskf_pkg::REG_MEAS_NOISE, 32'hFFFF_FFFF);
      set_register(tskf_pkg::REG_PROC_NOISE, 32'hFFFF_FFFF);
      send_sample(S_MAX, S_MIN, '0);
      send_sample(S_MIN, S_MAX, 32'hFFFF_FFFF);
      send_sample(S_MAX, S_MAX, S_MIN);
      send_sample('0, 32'h8000_0001, 32'h7FFF_FFFE);
   endtask

   // four traffic shapes, each under its own noise setting
   task automatic test_random_traffic();
      int idle_pct [4];
      int stall_pct [4];
      logic [tskf_pkg::CSR_DATA_W-1:0] r_val [4];
      logic [tskf_pkg::CSR_DATA_W-1:0] q_val [4];
      logic [DW-1:0] sx, sy, sz;
      idle_pct = '{0, 74, 0, 11};
      stall_pct = '{0, 0, 74, 11};
      r_val = '{$urandom_range(1 << 24, 1), 32'hFFFF_FFFF, 32'h1, $urandom()};
      q_val = '{$urandom_range(1 << 20, 0), 32'h0, $urandom_range(65536, 0), $urandom()};
      for (int ph = 0; ph < 4; ph++) begin
         set_register(tskf_pkg::REG_MEAS_NOISE, r_val[ph]);
         set_register(tskf_pkg::REG_PROC_NOISE, q_val[ph]);
         send_idle_pct = idle_pct[ph];
         sink_stall_pct = stall_pct[ph];
         for (int n = 0; n < 300; n++) begin
            sx = pick_sample(0);
            sy = pick_sample(1);
            sz = pick_sample(2);
            send_sample(sx, sy, sz);
         end
         send_idle_pct = 0;
         sink_stall_pct = 0;
         settle();
      end
      // back to the power-on noise values for a short closing burst
      set_register(tskf_pkg::REG_MEAS_NOISE, tskf_pkg::MEAS_NOISE_RESET);
      set_register(tskf_pkg::REG_PROC_NOISE, tskf_pkg::PROC_NOISE_RESET);
      for (int n = 0; n < 20; n++) begin
         send_sample(pick_sample(0), pick_sample(1), pick_sample(2));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_state();
      test_zero_noise();
      test_variance_saturation();
      test_random_traffic();
      settle();
      if (pending_estimates.size() != 0) begin
         note_mismatch($sformatf("%0d estimate words never arrived", pending_estimates.size()));
      end
      $display("summary: %0d velocity samples, %0d estimate words checked, %0d noise writes",
         samples_sent, words_checked, reg_writes);
      $display("summary: gain one, zero gain, variance saturation and four stall patterns run");
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("watchdog: run did not complete, %0d words pending", pending_estimates.size());
      $display("testbench: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tskf_pkg.sv
rtl/tskf_csr.sv
rtl/tskf_lane.sv
rtl/tskf_merge.sv
rtl/three_axis_scalar_kalman_filter.sv
bench/testbench.sv
